>>> design/list_pkg.sv
// ----------------------------------------------------------------------------
// list_pkg
// Shared types and constants for the LRU identity slot table.
// ----------------------------------------------------------------------------
`default_nettype none

package list_pkg;

	localparam int NUM_SLOTS = 8;
	localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
	localparam int KEY_W     = 64;
	localparam int STAMP_W   = 32;
	localparam int OUT_IDX_W = 3;

	localparam logic [1:0] ACT_LOOKUP  = 2'd0;
	localparam logic [1:0] ACT_ACQUIRE = 2'd1;
	localparam logic [1:0] ACT_CLEAR   = 2'd2;

	// search token that walks down the cell row
	typedef struct packed {
		logic               hit;
		logic [IDX_W-1:0]   hit_idx;
		logic               free;
		logic [IDX_W-1:0]   free_idx;
		logic [IDX_W-1:0]   lru_idx;
		logic [STAMP_W-1:0] lru_stamp;
	} probe_t;

	// all-ones stamp at the head so slot 0 wins an all-ones tie
	localparam probe_t PROBE_INIT = '{
		hit:       1'b0,
		hit_idx:   '0,
		free:      1'b0,
		free_idx:  '0,
		lru_idx:   '0,
		lru_stamp: '1
	};

	// update broadcast to every cell
	typedef struct packed {
		logic               clear;
		logic               wr_en;
		logic               set_key;
		logic [IDX_W-1:0]   idx;
		logic [KEY_W-1:0]   key;
		logic [STAMP_W-1:0] stamp;
	} wr_cmd_t;

	function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] idx);
		logic [IDX_W+OUT_IDX_W-1:0] w;
		w = {{OUT_IDX_W{1'b0}}, idx};
		return w[OUT_IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> design/list_cell.sv
// ----------------------------------------------------------------------------
// list_cell
// One table slot: holds a key and a use stamp, folds its own compare into the
// passing search token and registers the token for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module list_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [list_pkg::IDX_W-1:0] cell_idx,
	input  wire logic [list_pkg::KEY_W-1:0] search_key,
	input  wire list_pkg::probe_t          probe_in,
	output list_pkg::probe_t               probe_out,
	input  wire list_pkg::wr_cmd_t         wr_cmd
);
	import list_pkg::*;

	logic [KEY_W-1:0]   key_q;
	logic [STAMP_W-1:0] stamp_q;
	probe_t             probe_nxt;
	probe_t             probe_q;

	always_comb begin
		probe_nxt = probe_in;
		if (!probe_in.hit && key_q == search_key) begin
			probe_nxt.hit     = 1'b1;
			probe_nxt.hit_idx = cell_idx;
		end
		if (!probe_in.free && key_q == '0) begin
			probe_nxt.free     = 1'b1;
			probe_nxt.free_idx = cell_idx;
		end
		// strict compare keeps the lowest index on ties
		if (stamp_q < probe_in.lru_stamp) begin
			probe_nxt.lru_idx   = cell_idx;
			probe_nxt.lru_stamp = stamp_q;
		end
	end

	always_ff @(posedge clk) begin
		probe_q <= probe_nxt;
	end

	assign probe_out = probe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			stamp_q <= '0;
		end else if (wr_cmd.clear) begin
			key_q   <= '0;
			stamp_q <= '0;
		end else if (wr_cmd.wr_en && wr_cmd.idx == cell_idx) begin
			if (wr_cmd.set_key) begin
				key_q <= wr_cmd.key;
			end
			stamp_q <= wr_cmd.stamp;
		end
	end

endmodule

`default_nettype wire

>>> design/lru_identity_slot_table_unit.sv
// The result enters the output register once the search token has passed
// every cell and the output has room. A new item is taken only in the idle
// state; the token walks the slot row one cell per clock, then resolve writes back.
// A new item is taken while a previous result still waits in the output reg.
// Reset (arst_n low, asynchronous) empties every slot, zeroes all stamps and
// the use counter; no clearing pass follows.
// ----------------------------------------------------------------------------
// lru_identity_slot_table_unit
// Fully associative identity table with LRU replacement built as a row of
// slot cells; a search token collects hit, first-free and oldest slot.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_identity_slot_table_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    action,
	input  wire logic [list_pkg::KEY_W-1:0]    key_identity,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               found,
	output logic                               slot_valid,
	output logic [list_pkg::OUT_IDX_W-1:0]     slot_index,
	output logic                               evicted_live
);
	import list_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [1:0]         act_q;
	logic [KEY_W-1:0]   search_key_q;
	logic [STAMP_W-1:0] use_cnt_q;

	logic                 out_valid_q;
	logic                 found_q;
	logic                 slot_valid_q;
	logic [OUT_IDX_W-1:0] slot_index_q;
	logic                 evicted_q;

	probe_t  probe_chain [NUM_SLOTS];
	probe_t  tail;
	wr_cmd_t wr_cmd;

	logic                 in_xact;
	logic                 resolve;
	logic                 r_found;
	logic                 r_valid;
	logic [IDX_W-1:0]     r_idx;
	logic                 r_evict;
	logic                 bump_cnt;
	logic [STAMP_W-1:0]   next_stamp;

	// ---------------- cell row ----------------
	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		probe_t            cin;
		logic [IDX_W-1:0]  cidx;
		if (i == 0) begin : g_head
			assign cin = PROBE_INIT;
		end else begin : g_body
			assign cin = probe_chain[i-1];
		end
		assign cidx = IDX_W'(i);
		list_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_idx   (cidx),
			.search_key (search_key_q),
			.probe_in   (cin),
			.probe_out  (probe_chain[i]),
			.wr_cmd     (wr_cmd)
		);
	end

	assign tail       = probe_chain[NUM_SLOTS-1];
	assign next_stamp = use_cnt_q + STAMP_W'(1);

	assign in_ready = (state_q == ST_IDLE);
	assign in_xact  = in_valid && in_ready;
	// resolve once the token has reached the tail; wait for output room
	assign resolve  = (state_q == ST_SCAN) && (cnt_q == CNT_W'(NUM_SLOTS))
	                  && (!out_valid_q || out_ready);

	// ---------------- resolve ----------------
	always_comb begin
		r_found  = 1'b0;
		r_valid  = 1'b0;
		r_idx    = '0;
		r_evict  = 1'b0;
		bump_cnt = 1'b0;
		wr_cmd   = '{clear: 1'b0, wr_en: 1'b0, set_key: 1'b0, idx: '0,
		             key: search_key_q, stamp: next_stamp};
		if (act_q == ACT_CLEAR) begin
			wr_cmd.clear = resolve;
		end else if (search_key_q != '0) begin
			if (act_q != ACT_ACQUIRE) begin
				r_found = tail.hit;
				r_valid = tail.hit;
				r_idx   = tail.hit ? tail.hit_idx : '0;
			end else if (tail.hit) begin
				r_found      = 1'b1;
				r_valid      = 1'b1;
				r_idx        = tail.hit_idx;
				bump_cnt     = 1'b1;
				wr_cmd.wr_en = resolve;
				wr_cmd.idx   = tail.hit_idx;
			end else begin
				r_valid        = 1'b1;
				r_idx          = tail.free ? tail.free_idx : tail.lru_idx;
				r_evict        = !tail.free;
				bump_cnt       = 1'b1;
				wr_cmd.wr_en   = resolve;
				wr_cmd.set_key = 1'b1;
				wr_cmd.idx     = r_idx;
			end
		end
	end

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			use_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xact) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (resolve) begin
						state_q <= ST_IDLE;
						if (act_q == ACT_CLEAR) begin
							use_cnt_q <= '0;
						end else if (bump_cnt) begin
							use_cnt_q <= next_stamp;
						end
					end else if (cnt_q != CNT_W'(NUM_SLOTS)) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xact) begin
			act_q        <= action;
			search_key_q <= key_identity;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resolve) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resolve) begin
			found_q      <= r_found;
			slot_valid_q <= r_valid;
			slot_index_q <= to_out_idx(r_idx);
			evicted_q    <= r_evict;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign slot_valid   = slot_valid_q;
	assign slot_index   = slot_index_q;
	assign evicted_live = evicted_q;

	// ---------------- assertions ----------------
	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_xact |=> (state_q == ST_SCAN) && (cnt_q == '0))
		else $error("transaction did not start a scan");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(NUM_SLOTS))
		else $error("scan counter overran slot row");

	a_found_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && found_q |-> slot_valid_q && !evicted_q)
		else $error("hit result without valid slot or with eviction");

	a_invalid_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !slot_valid_q |-> slot_index_q == '0 && !evicted_q)
		else $error("slot index nonzero on invalid result");

	a_resolve_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		resolve |=> out_valid_q && (state_q == ST_IDLE))
		else $error("resolve did not present a result");

endmodule

`default_nettype wire

>>> test/lru_slot_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_slot_table_checker
// Watches both channels of the LRU identity slot table. It predicts the
// result of each accepted request and compares every result field with the
// oldest prediction waiting. It reports the failure count and the number of
// results still due.
// ----------------------------------------------------------------------------

module lru_slot_table_checker
	import list_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_ready,
	input  wire logic [1:0]           action,
	input  wire logic [KEY_W-1:0]     key_identity,
	input  wire logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire logic                 found,
	input  wire logic                 slot_valid,
	input  wire logic [OUT_IDX_W-1:0] slot_index,
	input  wire logic                 evicted_live,
	output int                        fails,
	output int                        pending
);

	typedef struct packed {
		logic                 found;
		logic                 slot_valid;
		logic [OUT_IDX_W-1:0] slot_index;
		logic                 evicted_live;
	} slot_reply_t;

	logic [KEY_W-1:0]   held_keys   [NUM_SLOTS];
	logic [STAMP_W-1:0] held_stamps [NUM_SLOTS];
	logic [STAMP_W-1:0] use_count;
	slot_reply_t        replies_due [$];

	function automatic void empty_table();
		for (int i = 0; i < NUM_SLOTS; i++) begin
			held_keys[i]   = '0;
			held_stamps[i] = '0;
		end
		use_count = '0;
	endfunction

	// applies one request to the table copy and returns the reply it causes
	function automatic slot_reply_t table_access(input logic [1:0] act,
			input logic [KEY_W-1:0] key);
		slot_reply_t r;
		int hit_at;
		int free_at;
		int oldest;
		int pick;
		r       = '0;
		hit_at  = -1;
		free_at = -1;
		oldest  = 0;
		if (act == ACT_CLEAR) begin
			empty_table();
			return r;
		end
		if (key == '0)
			return r;
		for (int i = 0; i < NUM_SLOTS; i++)
			if (hit_at < 0 && held_keys[i] == key)
				hit_at = i;
		if (hit_at >= 0) begin
			r.found      = 1'b1;
			r.slot_valid = 1'b1;
			r.slot_index = OUT_IDX_W'(hit_at);
		end
		// anything but acquire is a plain lookup
		if (act != ACT_ACQUIRE)
			return r;
		use_count = use_count + 1'b1;
		if (hit_at >= 0) begin
			held_stamps[hit_at] = use_count;
			return r;
		end
		// first free slot wins; else oldest stamp, lowest index on a tie
		for (int i = 0; i < NUM_SLOTS && free_at < 0; i++) begin
			if (held_keys[i] == '0)
				free_at = i;
			else if (held_stamps[i] < held_stamps[oldest])
				oldest = i;
		end
		pick = (free_at >= 0) ? free_at : oldest;
		held_keys[pick]   = key;
		held_stamps[pick] = use_count;
		r.slot_valid   = 1'b1;
		r.slot_index   = OUT_IDX_W'(pick);
		r.evicted_live = (free_at < 0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		slot_reply_t want;
		if (!arst_n) begin
			empty_table();
			replies_due.delete();
			fails = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					fails++;
					$error("result transaction with no request waiting");
				end else begin
					want = replies_due.pop_front();
					if (found !== want.found) begin
						fails++;
						$error("found: expected %0d, got %0d", want.found, found);
					end
					if (slot_valid !== want.slot_valid) begin
						fails++;
						$error("slot_valid: expected %0d, got %0d",
							want.slot_valid, slot_valid);
					end
					if (slot_index !== want.slot_index) begin
						fails++;
						$error("slot_index: expected %0d, got %0d",
							want.slot_index, slot_index);
					end
					if (evicted_live !== want.evicted_live) begin
						fails++;
						$error("evicted_live: expected %0d, got %0d",
							want.evicted_live, evicted_live);
					end
				end
			end
			if (in_valid && in_ready)
				replies_due.push_back(table_access(action, key_identity));
		end
		pending = replies_due.size();
	end

endmodule

>>> test/tb_lru_identity_slot_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_identity_slot_table_unit
// Drives lookup, acquire, clear and unused requests into the table with random
// gaps and result stalls: a directed opening, then random traffic over small
// key pools. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------

module tb_lru_identity_slot_table_unit;
	import list_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int RUN_LIMIT = 600000;
	localparam int RAND_ITEMS = 1700;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic [1:0]           action = ACT_LOOKUP;
	logic [KEY_W-1:0]     key_identity = '0;
	logic                 out_ready = 1'b0;
	logic                 in_ready;
	logic                 out_valid;
	logic                 found;
	logic                 slot_valid;
	logic [OUT_IDX_W-1:0] slot_index;
	logic                 evicted_live;
	int                   fails;
	int                   pending;

	logic calm_in = 1'b0;
	logic calm_out = 1'b0;
	logic out_took = 1'b0;
	int   hold_left = 0;
	int   cycle_count = 0;

	lru_identity_slot_table_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .key_identity(key_identity),
		.out_valid(out_valid), .out_ready(out_ready),
		.found(found), .slot_valid(slot_valid),
		.slot_index(slot_index), .evicted_live(evicted_live)
	);

	lru_slot_table_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .key_identity(key_identity),
		.out_valid(out_valid), .out_ready(out_ready),
		.found(found), .slot_valid(slot_valid),
		.slot_index(slot_index), .evicted_live(evicted_live),
		.fails(fails), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= RUN_LIMIT) begin
			$display("** lru_identity_slot_table_unit: FAILED **");
			$finish;
		end
	end

	// result side: a fresh stall is drawn after every transaction
	always @(posedge clk) out_took <= out_valid && out_ready;

	always @(negedge clk) begin
		if (out_took)
			hold_left = calm_out ? 0 : $urandom_range(0, 18);
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// called and returns at a falling edge
	task automatic send_request(input logic [1:0] act, input logic [KEY_W-1:0] key);
		int gap;
		gap = calm_in ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		key_identity <= key;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	initial begin
		logic [KEY_W-1:0] pool [20];
		logic [KEY_W-1:0] d [6];
		logic [KEY_W-1:0] k_ones;
		logic [KEY_W-1:0] k_top;
		logic [KEY_W-1:0] key;
		logic [1:0]       act;
		int               pool_used;
		int               roll;

		k_ones = '1;
		k_top  = {1'b1, {(KEY_W-1){1'b0}}};
		for (int i = 0; i < 6; i++)
			d[i] = {$urandom, $urandom} | 64'd2;
		pool_used = 10;

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// empty table, zero key, then fill all slots
		send_request(ACT_LOOKUP, '0);
		send_request(ACT_LOOKUP, k_ones);
		send_request(ACT_ACQUIRE, '0);
		send_request(ACT_ACQUIRE, k_ones);
		send_request(ACT_ACQUIRE, 64'd1);
		send_request(ACT_ACQUIRE, k_top);
		for (int i = 0; i < 5; i++)
			send_request(ACT_ACQUIRE, d[i]);
		send_request(ACT_LOOKUP, k_top);
		// refresh slot 0, so the next miss evicts the key in slot 1
		send_request(ACT_ACQUIRE, k_ones);
		send_request(ACT_ACQUIRE, d[5]);
		send_request(ACT_UNUSED, k_top);
		send_request(ACT_UNUSED, 64'd1);
		send_request(ACT_ACQUIRE, 64'd1);
		send_request(ACT_LOOKUP, '0);
		send_request(ACT_CLEAR, k_ones);
		send_request(ACT_LOOKUP, k_ones);
		send_request(ACT_ACQUIRE, k_top);
		send_request(ACT_CLEAR, '0);
		drain_results();

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 150 == 0) begin
				calm_in  = ($urandom_range(0, 3) == 0);
				calm_out = ($urandom_range(0, 3) == 0);
				roll = $urandom_range(0, 2);
				pool_used = (roll == 0) ? 6 : (roll == 1) ? 10 : 20;
			end
			if (n % 250 == 0)
				for (int i = 0; i < 20; i++)
					pool[i] = {$urandom, $urandom};
			if (n == RAND_ITEMS / 2)
				drain_results();
			roll = $urandom_range(0, 99);
			act = (roll < 50) ? ACT_ACQUIRE :
				(roll < 94) ? ACT_LOOKUP :
				(roll < 96) ? ACT_CLEAR : ACT_UNUSED;
			roll = $urandom_range(0, 99);
			key = (roll < 88) ? pool[$urandom_range(0, pool_used - 1)] :
				(roll < 94) ? '0 : {$urandom, $urandom};
			send_request(act, key);
		end

		drain_results();
		repeat (NUM_SLOTS + 4) @(negedge clk);
		if (fails == 0)
			$display("** lru_identity_slot_table_unit: PASSED **");
		else
			$display("** lru_identity_slot_table_unit: FAILED **");
		$finish;
	end

endmodule

>>> filelist.f
design/list_pkg.sv
design/list_cell.sv
design/lru_identity_slot_table_unit.sv
test/lru_slot_table_checker.sv
test/tb_lru_identity_slot_table_unit.sv
